### hdl/vesl_pkg.sv
// Shared types and constants of the velocity estimator / slew limiter.
package vesl_pkg;

  localparam int unsigned STAMP_W    = 63;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned PER_W      = 30;
  localparam int unsigned LIM_W      = 31;
  localparam int unsigned CFG_W      = 31;
  localparam int unsigned FIELD_AXES = 3;

  // Serial datapath sizes.
  localparam int unsigned PROD_W    = 62;  // widest product: 2^32 * 1e9 < 2^62
  localparam int unsigned DIVS_W    = 63;  // divisor: gap, bit 63 known zero
  localparam int unsigned QUO_W     = 32;  // quotient bits developed
  localparam int unsigned MUL_STEPS = 30;  // multiplier bits, 1e9 and period fit 30 bits
  localparam int unsigned CNT_W     = 5;

  localparam logic [PER_W-1:0] NS_PER_S = 30'd1_000_000_000;
  localparam logic [LIM_W-1:0] SAT_MAG  = 31'h7FFF_FFFF;

  localparam logic [CFG_W-1:0] RST_MAX_ACCEL = 31'd1_000_000;
  localparam logic [CFG_W-1:0] RST_MAX_SPEED = 31'd300_000;
  localparam logic [PER_W-1:0] RST_MIN_INT   = 30'd100_000;
  localparam logic [PER_W-1:0] RST_DEF_PER   = 30'd1_000_000;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_FINISH = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    REG_MAX_ACCEL = 2'd0,
    REG_MAX_SPEED = 2'd1,
    REG_MIN_INT   = 2'd2,
    REG_DEF_PER   = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAP,
    ST_LOAD,
    ST_MUL,
    ST_DIVCHK,
    ST_DIV,
    ST_TGT,
    ST_RECORD,
    ST_SLEW,
    ST_OUT
  } state_e;

endpackage

### hdl/velocity_estimate_slew_limiter.sv
// Finite-difference velocity estimator with slew-rate limited command output.
//
// Usage: s_axis carries one beat per item; tuser holds the action (sample,
// tick, finish). A sample beat updates the per-axis target velocity
// (dpos * 1e9 / dt, saturated to 32 bits) when a previous sample exists and
// the stamp gap exceeds min_int, and produces no output. A tick beat moves each
// commanded velocity toward its target by at most max_accel * period / 1e9,
// clamps it to +-max_speed and emits one m_axis beat. A finish beat zeroes the
// commands and emits a beat with tuser = 1.
// Targets and slew steps come from one shared shift-add multiplier (one
// multiplier bit per cycle) and one radix-2 restoring divider (one quotient
// bit per cycle); a sample runs both once per axis, a tick once.
// One item is in flight at a time. The result sits in an output register,
// so a new item is taken while that beat waits; a stalled receiver holds
// back a tick or finish only in its output state. Reset restores the register
// defaults and clears all samples, targets and commands. The config port must
// be written only while idle; the block itself does not enforce this.
module velocity_estimate_slew_limiter
  import vesl_pkg::*;
#(
  parameter int unsigned AXES = 3
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write port
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [30:0]  cfg_wdata_i,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // stamp_ns[62:0], pos_x[94:63], pos_y[126:95], pos_z[158:127],
  // period_ns[188:159], zero pad [191:189]
  input  logic [191:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]   s_axis_tuser,
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // vel_x[31:0], vel_y[63:32], vel_z[95:64]
  output logic [95:0]  m_axis_tdata,
  // finished[0]
  output logic [0:0]   m_axis_tuser
);

  localparam int unsigned AXW = (AXES > 1) ? $clog2(AXES) : 1;
  // axes that have position fields and velocity outputs
  localparam int unsigned NFA = (AXES < FIELD_AXES) ? AXES : FIELD_AXES;

  // ---------------------------------------------------------------------
  // input beat fields
  // ---------------------------------------------------------------------
  logic [STAMP_W-1:0]     in_stamp;
  logic signed [POS_W-1:0] in_pos [FIELD_AXES];
  logic [PER_W-1:0]       in_period;
  action_e                in_act;
  logic                   in_acc;

  assign in_stamp  = s_axis_tdata[62:0];
  assign in_pos[0] = s_axis_tdata[94:63];
  assign in_pos[1] = s_axis_tdata[126:95];
  assign in_pos[2] = s_axis_tdata[158:127];
  assign in_period = s_axis_tdata[188:159];
  assign in_act    = action_e'(s_axis_tuser);

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------
  state_e state_q, state_d;

  logic [CFG_W-1:0] max_accel_q, max_speed_q;
  logic [PER_W-1:0] min_int_q, def_per_q;

  logic                    have_sample_q;
  logic [STAMP_W-1:0]      prev_stamp_q;
  logic signed [POS_W-1:0] prev_pos_q [AXES];
  logic signed [POS_W-1:0] tgt_q      [AXES];
  logic signed [POS_W-1:0] cmd_q      [AXES];

  logic [AXW-1:0]   axis_q;
  logic [CNT_W-1:0] cnt_q;
  logic             is_tick_q;
  logic             m_vld_q;

  // payload, no reset
  logic signed [POS_W-1:0] pos_q [FIELD_AXES];
  logic [63:0]             gap_q;
  logic [PROD_W-1:0]       mul_a_q, acc_q;
  logic [PER_W-1:0]        mul_b_q;
  logic [DIVS_W-1:0]       div_d_q;
  logic [PROD_W-1:0]       rem_q;
  logic [QUO_W-1:0]        num_q, quo_q;
  logic                    ovf_q, neg_q, fin_q, out_fin_q;
  logic signed [POS_W-1:0] out_vel_q [FIELD_AXES];

  // ---------------------------------------------------------------------
  // datapath helpers
  // ---------------------------------------------------------------------
  logic                    upd_tgt, last_axis, out_free;
  logic signed [POS_W-1:0] pos_sel;
  logic signed [POS_W:0]   dpos;
  logic [POS_W:0]          dmag;
  logic [DIVS_W-1:0]       trial;
  logic                    trial_ge;
  logic [LIM_W-1:0]        tgt_mag;
  logic signed [POS_W+1:0] sl_diff, sl_step, sl_next, sl_lim;
  logic [PER_W-1:0]        per_sel;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign last_axis     = (axis_q == AXW'(AXES - 1));
  assign out_free      = !m_vld_q || m_axis_tready;
  assign per_sel       = (in_period == '0) ? def_per_q : in_period;

  // a gap that wrapped negative, or is too short, leaves targets alone
  assign upd_tgt = have_sample_q && !gap_q[63] &&
                   (gap_q[62:0] > {33'b0, min_int_q});

  // axes past the position fields see position zero
  always_comb begin
    pos_sel = '0;
    for (int i = 0; i < FIELD_AXES; i++) begin
      if (int'(axis_q) == i) begin
        pos_sel = pos_q[i];
      end
    end
  end

  assign dpos = $signed({pos_sel[POS_W-1], pos_sel}) -
                $signed({prev_pos_q[axis_q][POS_W-1], prev_pos_q[axis_q]});
  assign dmag = dpos[POS_W] ? (POS_W+1)'(-dpos) : dpos;

  // restoring divider step: shift in the next dividend bit, try subtract
  assign trial    = {rem_q, num_q[QUO_W-1]};
  assign trial_ge = (trial >= div_d_q);

  // quotient >= 2^31 saturates the target
  assign tgt_mag = (ovf_q || quo_q[QUO_W-1]) ? SAT_MAG : quo_q[LIM_W-1:0];

  // slew step for the current axis
  assign sl_step = $signed({2'b00, quo_q});
  assign sl_lim  = $signed({3'b000, max_speed_q});
  assign sl_diff = (POS_W+2)'(tgt_q[axis_q]) - (POS_W+2)'(cmd_q[axis_q]);

  always_comb begin
    if (sl_diff > sl_step) begin
      sl_next = (POS_W+2)'(cmd_q[axis_q]) + sl_step;
    end else if (sl_diff < -sl_step) begin
      sl_next = (POS_W+2)'(cmd_q[axis_q]) - sl_step;
    end else begin
      sl_next = (POS_W+2)'(tgt_q[axis_q]);
    end
    if (sl_next > sl_lim) begin
      sl_next = sl_lim;
    end
    if (sl_next < -sl_lim) begin
      sl_next = -sl_lim;
    end
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_act)
            ACT_SAMPLE: state_d = ST_GAP;
            ACT_TICK:   state_d = ST_MUL;
            ACT_FINISH: state_d = ST_OUT;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_GAP:    state_d = upd_tgt ? ST_LOAD : ST_RECORD;
      ST_LOAD:   state_d = ST_MUL;
      ST_MUL: begin
        if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
          state_d = ST_DIVCHK;
        end
      end
      ST_DIVCHK: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == CNT_W'(QUO_W - 1)) begin
          state_d = is_tick_q ? ST_SLEW : ST_TGT;
        end
      end
      ST_TGT:    state_d = last_axis ? ST_RECORD : ST_LOAD;
      ST_RECORD: state_d = ST_IDLE;
      ST_SLEW:   state_d = last_axis ? ST_OUT : ST_SLEW;
      ST_OUT:    state_d = out_free ? ST_IDLE : ST_OUT;
      default:   state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // control and architectural state
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_accel_q   <= RST_MAX_ACCEL;
      max_speed_q   <= RST_MAX_SPEED;
      min_int_q     <= RST_MIN_INT;
      def_per_q     <= RST_DEF_PER;
      have_sample_q <= 1'b0;
      prev_stamp_q  <= '0;
      for (int i = 0; i < AXES; i++) begin
        prev_pos_q[i] <= '0;
        tgt_q[i]      <= '0;
        cmd_q[i]      <= '0;
      end
      axis_q    <= '0;
      cnt_q     <= '0;
      is_tick_q <= 1'b0;
      m_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_MAX_ACCEL: max_accel_q <= cfg_wdata_i;
          REG_MAX_SPEED: max_speed_q <= cfg_wdata_i;
          REG_MIN_INT:   min_int_q   <= cfg_wdata_i[PER_W-1:0];
          REG_DEF_PER:   def_per_q   <= cfg_wdata_i[PER_W-1:0];
          default:       ;
        endcase
      end

      // output register: load a new beat, or drop the one just taken
      if (state_q == ST_OUT && out_free) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_vld_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          cnt_q  <= '0;
          axis_q <= '0;
          if (in_acc) begin
            case (in_act)
              ACT_SAMPLE: begin
                prev_stamp_q <= in_stamp;
                is_tick_q    <= 1'b0;
              end
              ACT_TICK: is_tick_q <= 1'b1;
              ACT_FINISH: begin
                for (int i = 0; i < AXES; i++) begin
                  cmd_q[i] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_LOAD, ST_DIVCHK: cnt_q <= '0;
        ST_MUL, ST_DIV:     cnt_q <= cnt_q + CNT_W'(1);
        ST_TGT: begin
          tgt_q[axis_q] <= neg_q ? -$signed({1'b0, tgt_mag}) : $signed({1'b0, tgt_mag});
          axis_q        <= axis_q + AXW'(1);
        end
        ST_RECORD: begin
          have_sample_q <= 1'b1;
          for (int i = int'(NFA); i < AXES; i++) begin
            prev_pos_q[i] <= '0;
          end
          for (int i = 0; i < NFA; i++) begin
            prev_pos_q[i] <= pos_q[i];
          end
        end
        ST_SLEW: begin
          cmd_q[axis_q] <= sl_next[POS_W-1:0];
          if (!last_axis) begin
            axis_q <= axis_q + AXW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // serial multiplier / divider and output payload
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          for (int i = 0; i < FIELD_AXES; i++) begin
            pos_q[i] <= in_pos[i];
          end
          gap_q   <= {1'b0, in_stamp} - {1'b0, prev_stamp_q};
          // step = max_accel * period / 1e9
          mul_a_q <= PROD_W'(max_accel_q);
          mul_b_q <= per_sel;
          acc_q   <= '0;
          div_d_q <= DIVS_W'(NS_PER_S);
          fin_q   <= (in_act == ACT_FINISH);
        end
      end
      ST_GAP: div_d_q <= gap_q[DIVS_W-1:0];
      ST_LOAD: begin
        // target = |dpos| * 1e9 / gap
        neg_q   <= dpos[POS_W];
        mul_a_q <= PROD_W'(dmag);
        mul_b_q <= NS_PER_S;
        acc_q   <= '0;
      end
      ST_MUL: begin
        if (mul_b_q[0]) begin
          acc_q <= acc_q + mul_a_q;
        end
        mul_a_q <= {mul_a_q[PROD_W-2:0], 1'b0};
        mul_b_q <= {1'b0, mul_b_q[PER_W-1:1]};
      end
      ST_DIVCHK: begin
        // high part already >= divisor: quotient needs more than 32 bits
        ovf_q <= ({33'b0, acc_q[PROD_W-1:QUO_W]} >= div_d_q);
        rem_q <= PROD_W'(acc_q[PROD_W-1:QUO_W]);
        num_q <= acc_q[QUO_W-1:0];
        quo_q <= '0;
      end
      ST_DIV: begin
        rem_q <= trial_ge ? PROD_W'(trial - div_d_q) : trial[PROD_W-1:0];
        num_q <= {num_q[QUO_W-2:0], 1'b0};
        quo_q <= {quo_q[QUO_W-2:0], trial_ge};
      end
      ST_OUT: begin
        if (out_free) begin
          out_fin_q <= fin_q;
          for (int i = int'(NFA); i < FIELD_AXES; i++) begin
            out_vel_q[i] <= '0;
          end
          for (int i = 0; i < NFA; i++) begin
            out_vel_q[i] <= fin_q ? '0 : cmd_q[i];
          end
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid   = m_vld_q;
  assign m_axis_tdata    = {out_vel_q[2], out_vel_q[1], out_vel_q[0]};
  assign m_axis_tuser[0] = out_fin_q;

  // commands inside the speed clamp, for the checks below
  logic cmd_in_lim;
  always_comb begin
    cmd_in_lim = 1'b1;
    for (int i = 0; i < AXES; i++) begin
      if ((POS_W+2)'(cmd_q[i]) > sl_lim || (POS_W+2)'(cmd_q[i]) < -sl_lim) begin
        cmd_in_lim = 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // a finish beat always carries zero velocities
  a_fin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_vld_q && out_fin_q |-> m_axis_tdata == '0)
    else $error("finish beat with nonzero velocity");

  // an output beat only starts out of the output state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_vld_q) |-> $past(state_q == ST_OUT))
    else $error("output beat raised outside output state");

  // divider remainder stays below the divisor when no overflow was seen
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV && !ovf_q |-> {1'b0, rem_q} < div_d_q)
    else $error("divider remainder out of range");

  // after a tick the commands respect the speed clamp
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT && !fin_q |-> cmd_in_lim)
    else $error("command velocity exceeds speed limit");
`endif

endmodule
